### hdl/srle_pkg.sv
// shared types and constants for the run-length sprite row decoder
`default_nettype none

package srle_pkg;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_SKIP,
    PH_RUNLEN,
    PH_PIXEL,
    PH_DONE
  } srle_phase_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       first_byte;
  } srle_in_t;

  typedef struct packed {
    logic       pixel_valid;
    logic [9:0] pixel_col;
    logic [9:0] pixel_row;
    logic [7:0] pixel_colour;
    logic       picture_done;
  } srle_out_t;

  typedef struct packed {
    srle_phase_t phase;
    logic [10:0] column;
    logic [10:0] row_index;
    logic [7:0]  row_byte_count;
    logic [9:0]  row_bytes_taken;
    logic [7:0]  run_left;
    logic [21:0] byte_index;
  } srle_state_t;

  typedef struct packed {
    logic [10:0] eff_width;
    logic [10:0] eff_height;
    logic [21:0] data_length;
  } srle_cfg_t;

  localparam logic [1:0] CFG_PIC_WIDTH   = 2'd0;
  localparam logic [1:0] CFG_PIC_HEIGHT  = 2'd1;
  localparam logic [1:0] CFG_DATA_LENGTH = 2'd2;

  localparam logic [10:0] COL_MAX      = 11'd2047;
  localparam logic [9:0]  TAKEN_MAX    = 10'd1023;
  localparam logic [21:0] BYTE_IDX_MAX = 22'h3F_FFFF;

  localparam srle_state_t STATE_RESET = '{
    phase:           PH_COUNT,
    column:          11'd0,
    row_index:       11'd0,
    row_byte_count:  8'd0,
    row_bytes_taken: 10'd0,
    run_left:        8'd0,
    byte_index:      22'd0
  };

endpackage

`default_nettype wire

### hdl/srle_step.sv
// next decoder state and result for one coded byte
`default_nettype none

module srle_step (
  input  srle_pkg::srle_state_t state,
  input  srle_pkg::srle_in_t    item,
  input  srle_pkg::srle_cfg_t   cfg,
  output srle_pkg::srle_state_t state_next,
  output srle_pkg::srle_out_t   result,
  output logic                  has_result
);
  import srle_pkg::*;

  srle_state_t cur;
  srle_state_t nx;
  logic [7:0]  b;
  logic [11:0] skip_sum;
  logic [10:0] col_inc;
  logic [10:0] col_after;
  logic [10:0] row_p1;
  logic [10:0] row_p2;
  logic [9:0]  taken_inc;
  logic [7:0]  run_dec;
  logic        len_hit_skip;
  logic        len_hit_row;
  logic        row_full;
  logic        pix;
  logic        done_now;

  always_comb begin
    cur = item.first_byte ? STATE_RESET : state;
    b   = item.code_byte;

    skip_sum  = {1'b0, cur.column} + {4'b0, b};
    col_inc   = (cur.column < COL_MAX) ? cur.column + 11'd1 : cur.column;
    col_after = (cur.phase == PH_PIXEL) ? col_inc : cur.column;
    row_p1    = cur.row_index + 11'd1;
    row_p2    = cur.row_index + 11'd2;
    taken_inc = (cur.row_bytes_taken < TAKEN_MAX) ? cur.row_bytes_taken + 10'd1
                                                  : cur.row_bytes_taken;
    run_dec   = cur.run_left - 8'd1;

    // index after the current byte (skip end) or after the next one (row end)
    len_hit_skip = ({1'b0, cur.byte_index} + 23'd1) >= {1'b0, cfg.data_length};
    len_hit_row  = ({2'b0, cur.byte_index} + 24'd2) >= {2'b0, cfg.data_length};
    row_full     = (col_after >= cfg.eff_width) ||
                   (taken_inc >= {2'b0, cur.row_byte_count});

    nx  = cur;
    pix = 1'b0;

    case (cur.phase)
      PH_COUNT: begin
        if (cur.row_index >= cfg.eff_height) begin
          nx.phase = PH_DONE;
        end else begin
          nx.row_byte_count  = b;
          nx.row_bytes_taken = 10'd1;
          if (b == 8'd0) begin
            nx.row_index = row_p1;
            nx.phase     = (row_p1 >= cfg.eff_height) ? PH_DONE : PH_COUNT;
          end else begin
            nx.column = 11'd0;
            nx.phase  = PH_SKIP;
          end
        end
      end
      PH_SKIP: begin
        if (skip_sum >= {1'b0, cfg.eff_width}) begin
          // skip reaching the width ends the row; the byte is the next row count
          if (len_hit_skip) begin
            nx.phase = PH_DONE;
          end else begin
            nx.row_index = row_p1;
            if (row_p1 >= cfg.eff_height) begin
              nx.phase = PH_DONE;
            end else begin
              nx.row_byte_count  = b;
              nx.row_bytes_taken = 10'd1;
              if (b == 8'd0) begin
                nx.row_index = row_p2;
                nx.phase     = (row_p2 >= cfg.eff_height) ? PH_DONE : PH_COUNT;
              end else begin
                nx.column = 11'd0;
                nx.phase  = PH_SKIP;
              end
            end
          end
        end else begin
          nx.column          = skip_sum[10:0];
          nx.row_bytes_taken = taken_inc;
          nx.phase           = PH_RUNLEN;
        end
      end
      PH_RUNLEN, PH_PIXEL: begin
        nx.row_bytes_taken = taken_inc;
        if (cur.phase == PH_PIXEL) begin
          pix         = cur.column < cfg.eff_width;
          nx.column   = col_inc;
          nx.run_left = run_dec;
        end else begin
          nx.run_left = b;
        end
        if ((cur.phase == PH_RUNLEN) && (b != 8'd0)) begin
          nx.phase = PH_PIXEL;
        end else if ((cur.phase == PH_PIXEL) && (run_dec != 8'd0)) begin
          nx.phase = PH_PIXEL;
        end else if (row_full) begin
          if (len_hit_row) begin
            nx.phase = PH_DONE;
          end else begin
            nx.row_index = row_p1;
            nx.phase     = (row_p1 >= cfg.eff_height) ? PH_DONE : PH_COUNT;
          end
        end else begin
          nx.phase = PH_SKIP;
        end
      end
      default: begin
        nx.phase = PH_DONE;
      end
    endcase

    nx.byte_index = (cur.byte_index < BYTE_IDX_MAX) ? cur.byte_index + 22'd1
                                                    : cur.byte_index;

    done_now = (nx.phase == PH_DONE) && (cur.phase != PH_DONE);

    result.pixel_valid  = pix;
    result.pixel_col    = pix ? cur.column[9:0] : 10'd0;
    result.pixel_row    = pix ? cur.row_index[9:0] : 10'd0;
    result.pixel_colour = pix ? b : 8'd0;
    result.picture_done = done_now;
    has_result          = pix || done_now;
    state_next          = nx;
  end

endmodule

`default_nettype wire

### hdl/srle_out_fifo.sv
// two-entry result buffer between the decode stage and the output channel
`default_nettype none

module srle_out_fifo (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  srle_pkg::srle_out_t push_data,
  output logic                full,
  output logic                out_valid,
  input  logic                out_stall,
  output srle_pkg::srle_out_t out_data
);
  import srle_pkg::*;

  srle_out_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;

  assign pop       = out_valid && !out_stall;
  assign full      = count == 2'd2;
  assign out_valid = count != 2'd0;
  assign out_data  = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    full |-> !push)
    else $error("result pushed into a full buffer");

  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count != 2'd3)
    else $error("result buffer count out of range");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (pop && !push) |=> (count == $past(count) - 2'd1))
    else $error("result buffer count lost a pop");

endmodule

`default_nettype wire

### hdl/sprite_rle_row_decoder_core.sv
// top level of the run-length sprite row decoder
// an accepted byte's result reaches the output through the input register, then
// the result buffer register; bytes that yield no result leave none
// throughput: one coded byte per cycle while the result buffer has room (decode is combinational)
// rst (synchronous) clears decode state and the buffers and sets all
// configuration registers to 1
`default_nettype none

module sprite_rle_row_decoder_core #(
  parameter int MAX_DIM = 1024
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  srle_pkg::srle_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output srle_pkg::srle_out_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [21:0]         cfg_data
);
  import srle_pkg::*;

  localparam logic [10:0] DIM_CAP = (MAX_DIM > 2047) ? 11'd2047 : 11'(MAX_DIM);

  srle_cfg_t   cfg;
  srle_state_t state;
  srle_state_t state_next;
  srle_in_t    s1_data;
  logic        s1_valid;
  srle_out_t   step_result;
  logic        step_has_result;
  logic        fifo_full;
  logic        fire;
  logic        push;
  logic [10:0] cfg_dim;

  assign cfg_ready = 1'b1;
  assign cfg_dim   = (cfg_data[10:0] < DIM_CAP) ? cfg_data[10:0] : DIM_CAP;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.eff_width   <= 11'd1;
      cfg.eff_height  <= 11'd1;
      cfg.data_length <= 22'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_PIC_WIDTH:   cfg.eff_width   <= cfg_dim;
        CFG_PIC_HEIGHT:  cfg.eff_height  <= cfg_dim;
        CFG_DATA_LENGTH: cfg.data_length <= cfg_data;
        default:         cfg             <= cfg;
      endcase
    end
  end

  // input register holds until the result buffer has room
  assign in_stall = s1_valid && fifo_full;
  assign fire     = s1_valid && !fifo_full;
  assign push     = fire && step_has_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!in_stall) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_data <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= STATE_RESET;
    end else if (fire) begin
      state <= state_next;
    end
  end

  srle_step u_step (
    .state      (state),
    .item       (s1_data),
    .cfg        (cfg),
    .state_next (state_next),
    .result     (step_result),
    .has_result (step_has_result)
  );

  srle_out_fifo u_out_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (step_result),
    .full      (fifo_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_done_sticky: assert property (@(posedge clk) disable iff (rst)
    (fire && state.phase == PH_DONE && !s1_data.first_byte) |=> state.phase == PH_DONE)
    else $error("decoder left the finished phase without a restart");

  a_push_meaningful: assert property (@(posedge clk) disable iff (rst)
    push |-> (step_result.pixel_valid || step_result.picture_done))
    else $error("empty result pushed");

  a_pixel_in_width: assert property (@(posedge clk) disable iff (rst)
    (push && step_result.pixel_valid) |-> (state.column < cfg.eff_width))
    else $error("pixel written past the picture width");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with an empty input register");

endmodule

`default_nettype wire
